[rtl/isfp_pkg.sv]
// isfp_pkg: shared types, byte codes and scaling constants for the imu serial frame parser
// no dependencies
`default_nettype none

package isfp_pkg;

  localparam int POS_W       = 4;
  localparam int FRAME_BYTES = 9;
  localparam int BIDX_W      = $clog2(FRAME_BYTES);
  localparam int N_WORDS     = 4;
  localparam int N_AXES      = 3;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);
  localparam int OUT_TDATA_W = 160;

  localparam logic [POS_W-1:0] POS_LAST = 4'd10;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_MAG   = 8'h54;

  localparam logic [4:0] MASK_ACCEL = 5'b10001;
  localparam logic [4:0] MASK_GYRO  = 5'b00010;
  localparam logic [4:0] MASK_ANGLE = 5'b00100;
  localparam logic [4:0] MASK_MAG   = 5'b01000;
  localparam logic [4:0] READY_BITS = 5'b10101;

  // accel: round(m * 313.8128) = m * 313 + floor((m * 1016 + 625) / 1250)
  localparam logic [23:0] ACC_INT      = 24'd313;
  localparam logic [24:0] ACC_FRAC_NUM = 25'd1016;
  localparam logic [24:0] ACC_HALF     = 25'd625;
  localparam logic [50:0] ACC_RECIP    = 51'd54975582;
  // temperature: floor((m * 32768 + 25) / 50)
  localparam logic [30:0] TMP_HALF     = 31'd25;
  localparam logic [62:0] TMP_RECIP    = 63'd2748779070;

  localparam logic [16:0] GYRO_SCALE  = 17'd4000;
  localparam logic [16:0] ANGLE_SCALE = 17'd360;
  localparam logic [16:0] MAG_SCALE   = 17'd65536;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2,
    KIND_MAG   = 2'd3
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t                kind;
    logic [N_WORDS-1:0][15:0]   word;
    logic [4:0]                 mask;
    logic [31:0]                count;
  } frame_rec_t;

endpackage

`default_nettype wire

[rtl/imu_serial_frame_parser.sv]
// imu_serial_frame_parser: top level, front parser, frame queue and scaling pipeline
// depends on isfp_pkg, isfp_front, isfp_fifo, isfp_scale
// throughput: one byte per cycle unless the queue is full; a frame needs eleven bytes
// a result shows on out_tvalid after its checksum byte is taken: the queue write on that
//   edge, then four pipeline registers in the scaling unit, held while out_tready is low
// in_tready drops only while the two-entry frame queue is full
// reset: synchronous active-low rst_n; hunting for a header, mask and frame count cleared
`default_nettype none

module imu_serial_frame_parser (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,   // rx_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // axis_x, axis_y, axis_z, temperature, valid_mask, telemetry_ready, frames_accepted
  output logic [isfp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [1:0]                         out_tuser   // frame_kind
);
  import isfp_pkg::*;

  logic       fire;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;
  frame_rec_t wr_rec;
  frame_rec_t rd_rec;

  assign in_tready = !full;
  assign fire      = in_tvalid && in_tready;

  isfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (in_tdata),
    .push    (push),
    .rec     (wr_rec)
  );

  isfp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (wr_rec),
    .pop     (pop),
    .rd_data (rd_rec),
    .full    (full),
    .empty   (empty)
  );

  isfp_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_data    (rd_rec),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

[rtl/isfp_front.sv]
// isfp_front: header hunt, byte collection and checksum check, one byte per cycle on fire
// depends on isfp_pkg; pushes decoded good frames into isfp_fifo
`default_nettype none

module isfp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire logic [7:0]         in_byte,
  output logic                    push,
  output isfp_pkg::frame_rec_t    rec
);
  import isfp_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [4:0]        mask_r, mask_nxt;
  logic [31:0]       cnt_r, cnt_nxt;
  logic [7:0]        bytes_r [FRAME_BYTES];
  logic              wr_en;
  logic [BIDX_W-1:0] wr_idx;
  logic              known;
  frame_kind_t       kind;
  logic [4:0]        kind_bits;

  assign wr_idx = BIDX_W'(pos_r - 4'd1);

  always_comb begin
    known     = 1'b1;
    kind      = KIND_ACCEL;
    kind_bits = MASK_ACCEL;
    case (bytes_r[0])
      TYPE_ACCEL: begin
        kind      = KIND_ACCEL;
        kind_bits = MASK_ACCEL;
      end
      TYPE_GYRO: begin
        kind      = KIND_GYRO;
        kind_bits = MASK_GYRO;
      end
      TYPE_ANGLE: begin
        kind      = KIND_ANGLE;
        kind_bits = MASK_ANGLE;
      end
      TYPE_MAG: begin
        kind      = KIND_MAG;
        kind_bits = MASK_MAG;
      end
      default: begin
        known     = 1'b0;
        kind_bits = '0;
      end
    endcase
  end

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    mask_nxt = mask_r;
    cnt_nxt  = cnt_r;
    wr_en    = 1'b0;
    push     = 1'b0;
    if (fire) begin
      if (pos_r == '0 || pos_r > POS_LAST) begin
        pos_nxt = '0;
        if (in_byte == HDR_BYTE) begin
          sum_nxt = HDR_BYTE;
          pos_nxt = 4'd1;
        end
      end else if (pos_r < POS_LAST) begin
        wr_en   = 1'b1;
        sum_nxt = sum_r + in_byte;
        pos_nxt = pos_r + 4'd1;
      end else begin
        pos_nxt = '0;
        if (sum_r == in_byte) begin
          cnt_nxt = cnt_r + 32'd1;
          if (known) begin
            mask_nxt = mask_r | kind_bits;
            push     = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    rec.kind  = kind;
    for (int i = 0; i < N_WORDS; i++) begin
      rec.word[i] = {bytes_r[2 + 2 * i], bytes_r[1 + 2 * i]};
    end
    rec.mask  = mask_r | kind_bits;
    rec.count = cnt_r + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= '0;
      mask_r <= '0;
      cnt_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      mask_r <= mask_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bytes_r[wr_idx] <= in_byte;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("byte position out of range");

  a_push_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (pos_r == POS_LAST && sum_r == in_byte))
    else $error("frame pushed away from a good checksum byte");

endmodule

`default_nettype wire

[rtl/isfp_fifo.sv]
// isfp_fifo: short frame queue between the front parser and the scaling pipeline
// depends on isfp_pkg
`default_nettype none

module isfp_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire isfp_pkg::frame_rec_t wr_data,
  input  wire logic                 pop,
  output isfp_pkg::frame_rec_t      rd_data,
  output logic                      full,
  output logic                      empty
);
  import isfp_pkg::*;

  frame_rec_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("frame queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("frame queue underflow");

endmodule

`default_nettype wire

[rtl/isfp_scale.sv]
// isfp_scale: four-stage pipeline turning raw frame words into q16 results
// depends on isfp_pkg; reads frames from isfp_fifo, drives the result channel
`default_nettype none

module isfp_scale (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire isfp_pkg::frame_rec_t   rd_data,
  input  wire logic                   empty,
  output logic                        pop,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [isfp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                  out_tuser
);
  import isfp_pkg::*;

  logic adv;
  logic v1_r, v2_r, v3_r, ov_r;

  // stage 1: sign and magnitude
  frame_kind_t               kind1_r;
  logic [4:0]                mask1_r;
  logic [31:0]               cnt1_r;
  logic signed [15:0]        raw1_r [N_AXES];
  logic [15:0]               mag1_r [N_WORDS];
  logic                      neg1_r [N_WORDS];

  // stage 2: constant products
  frame_kind_t               kind2_r;
  logic [4:0]                mask2_r;
  logic [31:0]               cnt2_r;
  logic [24:0]               ax2_r  [N_AXES];
  logic [23:0]               base2_r [N_AXES];
  logic [31:0]               exact2_r [N_AXES];
  logic                      neg2_r [N_WORDS];
  logic [30:0]               tx2_r;

  // stage 3: reciprocal products
  frame_kind_t               kind3_r;
  logic [4:0]                mask3_r;
  logic [31:0]               cnt3_r;
  logic [14:0]               q3_r   [N_AXES];
  logic [23:0]               base3_r [N_AXES];
  logic [31:0]               exact3_r [N_AXES];
  logic                      neg3_r [N_WORDS];
  logic [24:0]               qt3_r;

  // output register
  frame_kind_t               kind_o_r;
  logic [31:0]               axis_o_r [N_AXES];
  logic [25:0]               temp_o_r;
  logic [4:0]                mask_o_r;
  logic                      rdy_o_r;
  logic [31:0]               cnt_o_r;

  logic [16:0]               scale;
  logic [50:0]               prod_a [N_AXES];
  logic [62:0]               prod_t;
  logic [24:0]               acc_val [N_AXES];
  logic [31:0]               acc_ext [N_AXES];
  logic [25:0]               tmp_ext;
  logic signed [33:0]        prod_x [N_AXES];

  assign adv = !ov_r || out_tready;
  assign pop = adv && !empty;

  always_comb begin
    case (kind1_r)
      KIND_GYRO:  scale = GYRO_SCALE;
      KIND_ANGLE: scale = ANGLE_SCALE;
      KIND_MAG:   scale = MAG_SCALE;
      default:    scale = GYRO_SCALE;
    endcase
    for (int i = 0; i < N_AXES; i++) begin
      prod_x[i] = raw1_r[i] * $signed({1'b0, scale});
      prod_a[i] = 51'(ax2_r[i]) * ACC_RECIP;
      acc_val[i] = 25'(base3_r[i]) + 25'(q3_r[i]);
      acc_ext[i] = neg3_r[i] ? 32'(-{7'b0, acc_val[i]}) : {7'b0, acc_val[i]};
    end
    prod_t  = 63'(tx2_r) * TMP_RECIP;
    tmp_ext = neg3_r[N_WORDS-1] ? 26'(-{1'b0, qt3_r}) : {1'b0, qt3_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      ov_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1_r <= rd_data.kind;
      mask1_r <= rd_data.mask;
      cnt1_r  <= rd_data.count;
      for (int i = 0; i < N_AXES; i++) begin
        raw1_r[i] <= $signed(rd_data.word[i]);
      end
      for (int i = 0; i < N_WORDS; i++) begin
        neg1_r[i] <= rd_data.word[i][15];
        mag1_r[i] <= rd_data.word[i][15] ? 16'(-rd_data.word[i]) : rd_data.word[i];
      end

      kind2_r <= kind1_r;
      mask2_r <= mask1_r;
      cnt2_r  <= cnt1_r;
      for (int i = 0; i < N_AXES; i++) begin
        ax2_r[i]    <= 25'(mag1_r[i]) * ACC_FRAC_NUM + ACC_HALF;
        base2_r[i]  <= 24'(mag1_r[i]) * ACC_INT;
        exact2_r[i] <= prod_x[i][31:0];
      end
      for (int i = 0; i < N_WORDS; i++) begin
        neg2_r[i] <= neg1_r[i];
      end
      tx2_r <= {mag1_r[N_WORDS-1], 15'b0} + TMP_HALF;

      kind3_r <= kind2_r;
      mask3_r <= mask2_r;
      cnt3_r  <= cnt2_r;
      for (int i = 0; i < N_AXES; i++) begin
        q3_r[i]     <= prod_a[i][50:36];
        base3_r[i]  <= base2_r[i];
        exact3_r[i] <= exact2_r[i];
      end
      for (int i = 0; i < N_WORDS; i++) begin
        neg3_r[i] <= neg2_r[i];
      end
      qt3_r <= prod_t[61:37];

      kind_o_r <= kind3_r;
      mask_o_r <= mask3_r;
      rdy_o_r  <= ((mask3_r & READY_BITS) == READY_BITS);
      cnt_o_r  <= cnt3_r;
      for (int i = 0; i < N_AXES; i++) begin
        axis_o_r[i] <= (kind3_r == KIND_ACCEL) ? acc_ext[i] : exact3_r[i];
      end
      temp_o_r <= (kind3_r == KIND_ACCEL) ? tmp_ext : '0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = kind_o_r;
  assign out_tdata  = {cnt_o_r, rdy_o_r, mask_o_r, temp_o_r,
                       axis_o_r[2], axis_o_r[1], axis_o_r[0]};

  a_temp_only_accel: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && kind_o_r != KIND_ACCEL) |-> (temp_o_r == '0))
    else $error("temperature set on a non-accel result");

endmodule

`default_nettype wire
